// ----- rtl/dalarm_pkg.sv -----
// Package for the daily alarm table: opcodes, status codes, field types and sizes.
// No dependencies; rtl/daily_alarm_table_unit.sv imports it.
package dalarm_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int MAX_HOUR    = 23;
    localparam int MAX_MINUTE  = 59;
    localparam int DAY_MINUTES = 24 * 60;
    // Occupancy counter width, sized for the largest supported table (64 entries).
    localparam int COUNT_W     = 7;
    localparam int IN_DATA_W   = 19;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_DUP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_SKIPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_t;

    // Input tdata fields, lowest bits last.
    typedef struct packed {
        logic       repeat_flag;
        logic       enable_flag;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
    } in_data_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic       repeat_flag;
    } entry_t;

    // Result tdata fields, lowest bits last.
    typedef struct packed {
        logic [4:0]  entry_count;
        logic [10:0] minutes_away;
        logic [5:0]  alarm_minute;
        logic [4:0]  alarm_hour;
        logic        found;
        logic        fired;
        logic [2:0]  status;
    } result_t;

endpackage

// ----- rtl/daily_alarm_table_unit.sv -----
// Daily alarm table: add, tick, clear and next-alarm query over an entry memory.
// Depends on rtl/dalarm_pkg.sv.
//
//  Channel  Direction  Ports                          Contents
//  s_       in         s_tvalid s_tready s_tdata      hour, minute, second, enable, repeat
//                      s_tuser                        opcode
//  m_       out        m_tvalid m_tready m_tdata      status, flags, alarm time, distance, count
//
// Add, query and a tick at second zero that is not skipped walk the entry memory once:
// ENTRIES reads, the registered read of the last entry, a step to close the walk and the
// finish step. The next transaction is taken only once the block is back in idle.
// Clear, a skipped tick, a tick off second zero and an add or query with an out-of-range
// time go straight to the finish step.
// Reset clears the occupancy bits, the count and the tick memory at once; no sweep.
// A result waiting on m_ holds the finish step only; input is taken while it waits.
module daily_alarm_table_unit
    import dalarm_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] hour, [10:5] minute, [16:11] second, [17] enable_flag, [18] repeat_flag
    input  logic [23:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [3] fired, [4] found, [9:5] alarm_hour, [15:10] alarm_minute,
    // [26:16] minutes_away, [31:27] entry_count
    output logic [31:0] m_tdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RDC_W = IDX_W + 1;
    localparam logic [RDC_W-1:0] RD_END = RDC_W'(ENTRIES);

    // Control state.
    fsm_t               state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [16:0]        last_time_reg, last_time_next;
    logic               last_valid_reg, last_valid_next;
    logic [RDC_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Item and scan payload.
    opcode_t            op_reg, op_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         minute_reg, minute_next;
    logic               en_reg, en_next;
    logic               rp_reg, rp_next;
    status_t            pre_status_reg, pre_status_next;
    logic [10:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]   rd_sel_reg, rd_sel_next;
    logic               dup_reg, dup_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               fired_reg, fired_next;
    logic               found_reg, found_next;
    logic [4:0]         ah_reg, ah_next;
    logic [5:0]         am_reg, am_next;
    logic [10:0]        best_reg, best_next;
    logic [10:0]        away_reg, away_next;
    logic [ENTRIES-1:0] mark_reg, mark_next;
    logic [COUNT_W-1:0] free_cnt_reg, free_cnt_next;
    result_t            out_reg, out_next;

    // Entry memory.
    entry_t             mem [ENTRIES];
    entry_t             mem_q_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    // Decode of the incoming transaction.
    in_data_t           in_w;
    opcode_t            in_op;
    logic               in_accept;
    logic               in_bad_time;
    logic [16:0]        in_time;
    logic               in_skip;
    logic               in_scan;
    logic               out_free;
    logic               scan_done;

    // Scan arithmetic on the returned entry.
    logic               e_used;
    logic               e_match;
    logic [10:0]        slot_min;
    logic [11:0]        diff;
    logic [11:0]        diff_wrap;
    logic [10:0]        fwd_min;
    status_t            fin_status;
    logic [COUNT_W-1:0] count_after;

    assign in_w        = in_data_t'(s_tdata[IN_DATA_W-1:0]);
    assign in_op       = opcode_t'(s_tuser);
    assign in_accept   = s_tvalid && s_tready;
    assign in_bad_time = (in_w.hour > 5'(MAX_HOUR)) || (in_w.minute > 6'(MAX_MINUTE));
    assign in_time     = {in_w.hour, in_w.minute, in_w.second};
    assign in_skip     = last_valid_reg && (in_time == last_time_reg);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign scan_done   = (rd_cnt_reg == RD_END) && !rd_vld_reg;

    // Only adds and queries with a valid time, and ticks that may fire, walk the table.
    always_comb begin
        case (in_op)
            OP_ADD:   in_scan = !in_bad_time;
            OP_QUERY: in_scan = !in_bad_time;
            OP_TICK:  in_scan = !in_skip && (in_w.second == 6'd0);
            default:  in_scan = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_scan ? FSM_SCAN : FSM_FINISH;
                end
            end
            FSM_SCAN: begin
                if (scan_done) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        case (state_reg)
            FSM_IDLE: s_tready = 1'b1;
            FSM_SCAN: rd_en    = (rd_cnt_reg != RD_END);
            default: begin
                s_tready = 1'b0;
                rd_en    = 1'b0;
            end
        endcase
    end

    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    // Entry returned by the memory: occupancy, time match and forward distance.
    assign e_used    = used_reg[rd_sel_reg];
    assign e_match   = e_used && mem_q_reg.enabled && (mem_q_reg.hour == hour_reg)
                       && (mem_q_reg.minute == minute_reg);
    assign slot_min  = 11'(mem_q_reg.hour) * 11'(60) + 11'(mem_q_reg.minute);
    assign diff      = {1'b0, slot_min} - {1'b0, cur_reg};
    assign diff_wrap = diff + 12'(DAY_MINUTES);
    assign fwd_min   = diff[11] ? diff_wrap[10:0] : diff[10:0];

    // Datapath: capture, scan accumulation, write-back and commit.
    always_comb begin
        count_next      = count_reg;
        used_next       = used_reg;
        last_time_next  = last_time_reg;
        last_valid_next = last_valid_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_vld_next     = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        op_next         = op_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        en_next         = en_reg;
        rp_next         = rp_reg;
        pre_status_next = pre_status_reg;
        cur_next        = cur_reg;
        rd_sel_next     = rd_sel_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        fired_next      = fired_reg;
        found_next      = found_reg;
        ah_next         = ah_reg;
        am_next         = am_reg;
        best_next       = best_reg;
        away_next       = away_reg;
        mark_next       = mark_reg;
        free_cnt_next   = free_cnt_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_sel_reg;
        mem_wdata       = mem_q_reg;
        fin_status      = pre_status_reg;
        count_after     = count_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Capture a new transaction and reset the scan accumulators.
        if (in_accept) begin
            op_next         = in_op;
            hour_next       = in_w.hour;
            minute_next     = in_w.minute;
            en_next         = in_w.enable_flag;
            rp_next         = in_w.repeat_flag;
            cur_next        = 11'(in_w.hour) * 11'(60) + 11'(in_w.minute);
            rd_cnt_next     = '0;
            dup_next        = 1'b0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
            fired_next      = 1'b0;
            found_next      = 1'b0;
            ah_next         = '0;
            am_next         = '0;
            best_next       = 11'(DAY_MINUTES);
            away_next       = '0;
            mark_next       = '0;
            free_cnt_next   = '0;
            pre_status_next = ST_OK;
            if ((in_op == OP_ADD || in_op == OP_QUERY) && in_bad_time) begin
                pre_status_next = ST_INVALID;
            end
            if (in_op == OP_TICK) begin
                if (in_skip) begin
                    pre_status_next = ST_SKIPPED;
                end else begin
                    last_time_next  = in_time;
                    last_valid_next = 1'b1;
                end
            end
        end

        // Issue one read per cycle during the scan.
        if (rd_en) begin
            rd_cnt_next = rd_cnt_reg + RDC_W'(1);
            rd_vld_next = 1'b1;
            rd_sel_next = rd_addr;
        end

        // Fold in the entry read on the previous cycle.
        if (rd_vld_reg) begin
            case (op_reg)
                OP_ADD: begin
                    if (e_match) begin
                        dup_next = 1'b1;
                    end
                    if (!e_used && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_sel_reg;
                    end
                end
                OP_TICK: begin
                    if (e_match) begin
                        fired_next = 1'b1;
                        ah_next    = mem_q_reg.hour;
                        am_next    = mem_q_reg.minute;
                        // A one-time alarm disables itself once it has fired.
                        if (!mem_q_reg.repeat_flag) begin
                            mem_we            = 1'b1;
                            mem_wdata.enabled = 1'b0;
                        end
                    end
                    // Disabled one-time entries are freed if anything fires.
                    if (e_used && !mem_q_reg.repeat_flag && (!mem_q_reg.enabled || e_match))
                    begin
                        mark_next[rd_sel_reg] = 1'b1;
                        free_cnt_next         = free_cnt_reg + COUNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    if (e_used && mem_q_reg.enabled && (fwd_min < best_reg)) begin
                        best_next  = fwd_min;
                        found_next = 1'b1;
                        ah_next    = mem_q_reg.hour;
                        am_next    = mem_q_reg.minute;
                        away_next  = fwd_min;
                    end
                end
                default: begin
                    dup_next = dup_reg;
                end
            endcase
        end

        // Commit the item and load the result register.
        if (state_reg == FSM_FINISH && out_free) begin
            case (op_reg)
                OP_ADD: begin
                    if (pre_status_reg == ST_OK) begin
                        if (dup_reg) begin
                            fin_status = ST_DUP;
                        end else if (!free_found_reg) begin
                            fin_status = ST_FULL;
                        end else begin
                            mem_we                  = 1'b1;
                            mem_waddr               = free_idx_reg;
                            mem_wdata.hour          = hour_reg;
                            mem_wdata.minute        = minute_reg;
                            mem_wdata.enabled       = en_reg;
                            mem_wdata.repeat_flag   = rp_reg;
                            used_next[free_idx_reg] = 1'b1;
                            count_after             = count_reg + COUNT_W'(1);
                        end
                    end
                end
                OP_TICK: begin
                    if (fired_reg) begin
                        used_next   = used_reg & ~mark_reg;
                        count_after = count_reg - free_cnt_reg;
                    end
                end
                OP_CLEAR: begin
                    used_next   = '0;
                    count_after = '0;
                end
                default: begin
                    fin_status = pre_status_reg;
                end
            endcase
            count_next            = count_after;
            m_tvalid_next         = 1'b1;
            out_next.status       = fin_status;
            out_next.fired        = fired_reg;
            out_next.found        = found_reg;
            out_next.alarm_hour   = ah_reg;
            out_next.alarm_minute = am_reg;
            out_next.minutes_away = away_reg;
            out_next.entry_count  = count_after[4:0];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            count_reg      <= '0;
            used_reg       <= '0;
            last_time_reg  <= '0;
            last_valid_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            last_time_reg  <= last_time_next;
            last_valid_reg <= last_valid_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        hour_reg       <= hour_next;
        minute_reg     <= minute_next;
        en_reg         <= en_next;
        rp_reg         <= rp_next;
        pre_status_reg <= pre_status_next;
        cur_reg        <= cur_next;
        rd_sel_reg     <= rd_sel_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        fired_reg      <= fired_next;
        found_reg      <= found_next;
        ah_reg         <= ah_next;
        am_reg         <= am_next;
        best_reg       <= best_next;
        away_reg       <= away_next;
        mark_reg       <= mark_next;
        free_cnt_reg   <= free_cnt_next;
        out_reg        <= out_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // A write-back during the scan never targets the entry being read.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && rd_en) |-> (mem_waddr != rd_addr))
        else $error("entry write and read collide");

    // An add only lands in a free entry.
    a_add_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == FSM_FINISH) |-> !used_reg[mem_waddr])
        else $error("add overwrote an occupied entry");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> ($stable(out_reg) && m_tvalid_reg))
        else $error("result changed while stalled");

    // The occupancy count never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(ENTRIES))
        else $error("entry count out of range");

    // Each accepted transaction leaves the idle state on the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg != FSM_IDLE))
        else $error("transaction accepted without leaving idle");

endmodule

// ----- tb/alarm_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the daily alarm table: mirrors the alarm table from the input
// transactions and compares every result transaction. Depends on rtl/dalarm_pkg.sv.
module alarm_result_checker
    import dalarm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);

    // Mirror of the alarm table and the tick memory.
    logic        slot_busy  [DEF_ENTRIES];
    logic [4:0]  slot_hr    [DEF_ENTRIES];
    logic [5:0]  slot_min   [DEF_ENTRIES];
    logic        slot_on    [DEF_ENTRIES];
    logic        slot_daily [DEF_ENTRIES];
    logic [16:0] tick_memo;
    logic        tick_memo_valid;

    // Results predicted for accepted input transactions, oldest first.
    result_t pending_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one operation to the mirror and returns the result it should produce.
    function automatic result_t alarm_step_outcome(input opcode_t op, input in_data_t d);
        result_t     r;
        logic        dup;
        int          free_slot;
        int          cur;
        int          best;
        int          ahead;
        int          used;
        logic [16:0] stamp;
        r = '0;
        case (op)
            OP_ADD: begin
                if (d.hour > MAX_HOUR || d.minute > MAX_MINUTE) begin
                    r.status = ST_INVALID;
                end else begin
                    dup = 1'b0;
                    free_slot = -1;
                    for (int i = 0; i < DEF_ENTRIES; i++) begin
                        if (slot_busy[i]) begin
                            if (slot_on[i] && slot_hr[i] == d.hour && slot_min[i] == d.minute)
                                dup = 1'b1;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (dup) begin
                        r.status = ST_DUP;
                    end else if (free_slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_busy[free_slot]  = 1'b1;
                        slot_hr[free_slot]    = d.hour;
                        slot_min[free_slot]   = d.minute;
                        slot_on[free_slot]    = d.enable_flag;
                        slot_daily[free_slot] = d.repeat_flag;
                    end
                end
            end
            OP_TICK: begin
                stamp = {d.hour, d.minute, d.second};
                if (tick_memo_valid && stamp == tick_memo) begin
                    r.status = ST_SKIPPED;
                end else begin
                    tick_memo = stamp;
                    tick_memo_valid = 1'b1;
                    // Alarms go off only at the start of a minute.
                    if (d.second == 6'd0) begin
                        for (int i = 0; i < DEF_ENTRIES; i++) begin
                            if (slot_busy[i] && slot_on[i] &&
                                slot_hr[i] == d.hour && slot_min[i] == d.minute) begin
                                r.fired = 1'b1;
                                r.alarm_hour = slot_hr[i];
                                r.alarm_minute = slot_min[i];
                                if (!slot_daily[i])
                                    slot_on[i] = 1'b0;
                            end
                        end
                        // A firing sweeps out every spent one-time entry.
                        if (r.fired) begin
                            for (int i = 0; i < DEF_ENTRIES; i++)
                                if (slot_busy[i] && !slot_on[i] && !slot_daily[i])
                                    slot_busy[i] = 1'b0;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < DEF_ENTRIES; i++)
                    slot_busy[i] = 1'b0;
            end
            default: begin
                if (d.hour > MAX_HOUR || d.minute > MAX_MINUTE) begin
                    r.status = ST_INVALID;
                end else begin
                    cur = int'(d.hour) * 60 + int'(d.minute);
                    best = DAY_MINUTES;
                    for (int i = 0; i < DEF_ENTRIES; i++) begin
                        if (slot_busy[i] && slot_on[i]) begin
                            ahead = int'(slot_hr[i]) * 60 + int'(slot_min[i]) - cur;
                            if (ahead < 0)
                                ahead += DAY_MINUTES;
                            if (ahead < best) begin
                                best = ahead;
                                r.found = 1'b1;
                                r.alarm_hour = slot_hr[i];
                                r.alarm_minute = slot_min[i];
                                r.minutes_away = ahead[10:0];
                            end
                        end
                    end
                end
            end
        endcase
        used = 0;
        for (int i = 0; i < DEF_ENTRIES; i++)
            if (slot_busy[i])
                used++;
        r.entry_count = used[4:0];
        return r;
    endfunction

    // Results are checked before the same edge's input is predicted, so an extra
    // result can never pair with an expectation that was just created.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t predicted;
        if (!aresetn) begin
            for (int i = 0; i < DEF_ENTRIES; i++) begin
                slot_busy[i]  = 1'b0;
                slot_hr[i]    = '0;
                slot_min[i]   = '0;
                slot_on[i]    = 1'b0;
                slot_daily[i] = 1'b0;
            end
            tick_memo = '0;
            tick_memo_valid = 1'b0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected", got, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.fired != want.fired)
                        report_mismatch("fired", got.fired, want.fired);
                    if (got.found != want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.alarm_hour != want.alarm_hour)
                        report_mismatch("alarm_hour", got.alarm_hour, want.alarm_hour);
                    if (got.alarm_minute != want.alarm_minute)
                        report_mismatch("alarm_minute", got.alarm_minute, want.alarm_minute);
                    if (got.minutes_away != want.minutes_away)
                        report_mismatch("minutes_away", got.minutes_away, want.minutes_away);
                    if (got.entry_count != want.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.entry_count);
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = alarm_step_outcome(opcode_t'(s_tuser),
                                               in_data_t'(s_tdata[IN_DATA_W-1:0]));
                pending_results.insert(pending_results.size(), predicted);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the daily alarm table testbench: clock, reset, stimulus, receiver stalls
// and the verdict. Depends on rtl/dalarm_pkg.sv, rtl/daily_alarm_table_unit.sv and
// tb/alarm_result_checker.sv.
module tb_top
    import dalarm_pkg::*;
();

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          mismatches;
    int          outstanding;

    // Stimulus progress shared with the receiver process.
    int          sent = 0;
    bit          quiet = 1'b0;
    bit          squeeze_done = 1'b0;

    always #2 aclk = ~aclk;

    daily_alarm_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alarm_result_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offers one input transaction, possibly after an idle burst, and waits until
    // the block takes it. Valid stays high between back-to-back transactions.
    task automatic send_item(input opcode_t op, input int hr, input int mn, input int sc,
                             input int en, input int rp);
        in_data_t f;
        int       gap;
        f.hour        = hr[4:0];
        f.minute      = mn[5:0];
        f.second      = sc[5:0];
        f.enable_flag = en[0];
        f.repeat_flag = rp[0];
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(24 - IN_DATA_W){1'b0}}, f};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off that backs the block up.
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (!squeeze_done && sent >= 250) begin
                squeeze_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int now_min;
        int add_hr;
        int add_mn;
        int tick_hr;
        int tick_mn;
        int tick_sc;
        int pick;
        int sub;
        int k;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, first and repeated tick, add checks, query, firing.
        send_item(OP_QUERY, 0, 0, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0, 0);
        send_item(OP_ADD, 23, 59, 0, 1, 1);
        send_item(OP_ADD, 24, 0, 0, 1, 0);
        send_item(OP_ADD, 0, 60, 0, 1, 0);
        send_item(OP_ADD, 31, 63, 59, 1, 1);
        send_item(OP_ADD, 0, 0, 0, 1, 0);
        send_item(OP_ADD, 23, 59, 0, 0, 1);
        send_item(OP_ADD, 12, 30, 0, 0, 0);
        send_item(OP_ADD, 12, 30, 0, 1, 0);
        send_item(OP_QUERY, 31, 63, 0, 0, 0);
        send_item(OP_QUERY, 23, 59, 0, 0, 0);
        send_item(OP_QUERY, 12, 31, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 1, 0, 0);
        send_item(OP_TICK, 31, 63, 59, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0, 0);
        send_item(OP_TICK, 23, 59, 0, 0, 0);
        send_item(OP_TICK, 23, 59, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 5, 5, 0, 0, 0);
        // The tick memory survives a clear, so this one is skipped.
        send_item(OP_TICK, 23, 59, 0, 0, 0);

        // Random: a running clock with alarms set just ahead of it, so that ticks
        // fire often; duplicates, fills, clears and noise mixed in.
        now_min = $urandom_range(0, DAY_MINUTES - 1);
        add_hr = 0;
        add_mn = 0;
        tick_hr = 23;
        tick_mn = 59;
        tick_sc = 0;
        for (k = 0; k < 700; k++) begin
            quiet = (k >= 600);
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 9);
            if (pick < 3) begin
                // Fill the table past its capacity.
                repeat (17)
                    send_item(OP_ADD, $urandom_range(0, MAX_HOUR), $urandom_range(0, MAX_MINUTE),
                              $urandom_range(0, 59), 1, $urandom_range(0, 1));
                k += 16;
            end else if (pick < 38) begin
                if (sub < 4) begin
                    add_hr = ((now_min + $urandom_range(1, 4)) % DAY_MINUTES) / 60;
                    add_mn = ((now_min + $urandom_range(1, 4)) % DAY_MINUTES) % 60;
                end else if (sub < 8 && sub >= 6) begin
                    add_hr = $urandom_range(0, MAX_HOUR);
                    add_mn = $urandom_range(0, MAX_MINUTE);
                end else if (sub >= 8) begin
                    add_hr = $urandom_range(0, 31);
                    add_mn = $urandom_range(0, 63);
                end
                // Otherwise the previous time is reused to provoke duplicates.
                send_item(OP_ADD, add_hr, add_mn, $urandom_range(0, 59),
                          $urandom_range(0, 4) != 0, $urandom_range(0, 1));
            end else if (pick < 70) begin
                if (sub < 5) begin
                    now_min = (now_min + 1) % DAY_MINUTES;
                    tick_hr = now_min / 60;
                    tick_mn = now_min % 60;
                    tick_sc = 0;
                end else if (sub < 8 && sub >= 6) begin
                    tick_hr = now_min / 60;
                    tick_mn = now_min % 60;
                    tick_sc = $urandom_range(1, 59);
                end else if (sub >= 8) begin
                    tick_hr = $urandom_range(0, 31);
                    tick_mn = $urandom_range(0, 63);
                    tick_sc = $urandom_range(0, 59);
                end
                // Otherwise the last tick is repeated.
                send_item(OP_TICK, tick_hr, tick_mn, tick_sc, $urandom_range(0, 1),
                          $urandom_range(0, 1));
            end else if (pick < 92) begin
                if (sub < 4)
                    send_item(OP_QUERY, now_min / 60, now_min % 60, $urandom_range(0, 59),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                else if (sub < 8)
                    send_item(OP_QUERY, $urandom_range(0, MAX_HOUR),
                              $urandom_range(0, MAX_MINUTE), $urandom_range(0, 59),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                else
                    send_item(OP_QUERY, $urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom_range(0, 59), $urandom_range(0, 1),
                              $urandom_range(0, 1));
            end else if (pick < 96) begin
                send_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 59), $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                send_item(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 59),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain: every expected result must arrive; the watchdog bounds the wait.
        while (outstanding != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dalarm_pkg.sv
rtl/daily_alarm_table_unit.sv
tb/alarm_result_checker.sv
tb/tb_top.sv
